>>> hw/rtl/uspd_pkg.sv
// ----------------------------------------------------------------------------
// uspd_pkg: shared types and constants of the URI segment percent decoder
// Character codes, result kinds, parse modes and the step state/result types.
// ----------------------------------------------------------------------------
package uspd_pkg;

  // Width of the internal segment byte counter (range 4 to 32).
  localparam int unsigned LengthBits = 16;
  localparam int unsigned ReportBits = 16;

  // Characters of interest
  localparam logic [7:0] ChNul      = 8'h00;
  localparam logic [7:0] ChPercent  = 8'h25;
  localparam logic [7:0] ChSlash    = 8'h2F;
  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChHash     = 8'h23;

  // Result kinds
  localparam logic [3:0] KindByte       = 4'd0;
  localparam logic [3:0] KindPending    = 4'd1;
  localparam logic [3:0] KindEndSlash   = 4'd2;
  localparam logic [3:0] KindEndQuest   = 4'd3;
  localparam logic [3:0] KindEndHash    = 4'd4;
  localparam logic [3:0] KindEndText    = 4'd5;
  localparam logic [3:0] KindAbsorbed   = 4'd6;
  localparam logic [3:0] KindBadEsc     = 4'd7;
  localparam logic [3:0] KindDiscarded  = 4'd8;

  // Parse modes
  localparam logic [2:0] ModeSeg     = 3'd0;
  localparam logic [2:0] ModeEscHi   = 3'd1;
  localparam logic [2:0] ModeEscLo   = 3'd2;
  localparam logic [2:0] ModeAbsorb  = 3'd3;
  localparam logic [2:0] ModeDiscard = 3'd4;

  typedef struct packed {
    logic [2:0]            mode;
    logic [3:0]            nibble;
    logic [LengthBits-1:0] count;
  } parse_state_t;

  typedef struct packed {
    logic [3:0]            kind;
    logic [7:0]            data_byte;
    logic [ReportBits-1:0] seg_length;
  } parse_result_t;

  // Hex digit value; bit 4 set when the character is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    return v;
  endfunction

  // Saturate the internal count to the reported field width.
  function automatic logic [ReportBits-1:0] report_len(input logic [LengthBits-1:0] n);
    logic [31:0] wide;
    wide = 32'(n);
    if (wide > 32'h0000_FFFF) return '1;
    return wide[ReportBits-1:0];
  endfunction

endpackage

>>> hw/rtl/uspd_step.sv
// ----------------------------------------------------------------------------
// uspd_step: one character of the segment parser
// Computes the result and the next parse state from the current state.
// ----------------------------------------------------------------------------
module uspd_step import uspd_pkg::*; (
  input  logic [7:0]    ch_i,
  input  parse_state_t  state_i,
  output parse_state_t  state_o,
  output parse_result_t result_o
);

  logic [4:0]            hex;
  logic [LengthBits-1:0] count_inc;

  assign hex       = hex_value(ch_i);
  assign count_inc = (state_i.count == {LengthBits{1'b1}}) ? state_i.count
                                                            : state_i.count + 1'b1;

  always_comb begin
    state_o  = state_i;
    result_o = '{kind: KindByte, data_byte: 8'h00, seg_length: '0};
    case (state_i.mode)
      ModeDiscard: begin
        if (ch_i == ChNul) begin
          result_o.kind = KindEndText;
          state_o.mode  = ModeSeg;
          state_o.count = '0;
        end else begin
          result_o.kind = KindDiscarded;
        end
      end
      ModeEscHi, ModeEscLo: begin
        if (hex[4]) begin
          result_o.kind       = KindBadEsc;
          result_o.seg_length = report_len(state_i.count);
          state_o.mode        = (ch_i == ChNul) ? ModeSeg : ModeDiscard;
          state_o.count       = '0;
          state_o.nibble      = 4'h0;
        end else if (state_i.mode == ModeEscHi) begin
          result_o.kind       = KindPending;
          result_o.seg_length = report_len(state_i.count);
          state_o.mode        = ModeEscLo;
          state_o.nibble      = hex[3:0];
        end else begin
          result_o.kind       = KindByte;
          result_o.data_byte  = {state_i.nibble, hex[3:0]};
          result_o.seg_length = report_len(count_inc);
          state_o.mode        = ModeSeg;
          state_o.nibble      = 4'h0;
          state_o.count       = count_inc;
        end
      end
      default: begin
        if (state_i.mode == ModeAbsorb && ch_i == ChSlash) begin
          result_o.kind = KindAbsorbed;
        end else if (ch_i == ChNul) begin
          result_o.kind       = KindEndText;
          result_o.seg_length = report_len(state_i.count);
          state_o.mode        = ModeSeg;
          state_o.count       = '0;
        end else if (ch_i == ChSlash || ch_i == ChQuestion || ch_i == ChHash) begin
          result_o.kind       = (ch_i == ChSlash)    ? KindEndSlash :
                                (ch_i == ChQuestion) ? KindEndQuest : KindEndHash;
          result_o.seg_length = report_len(state_i.count);
          state_o.mode        = ModeAbsorb;
          state_o.count       = '0;
        end else if (ch_i == ChPercent) begin
          result_o.kind       = KindPending;
          result_o.seg_length = report_len(state_i.count);
          state_o.mode        = ModeEscHi;
        end else begin
          result_o.kind       = KindByte;
          result_o.data_byte  = ch_i;
          result_o.seg_length = report_len(count_inc);
          state_o.mode        = ModeSeg;
          state_o.count       = count_inc;
        end
      end
    endcase
  end

endmodule

>>> hw/rtl/uri_segment_percent_decoder.sv
// ----------------------------------------------------------------------------
// uri_segment_percent_decoder: URI path splitter with percent-decoding
// One character in, one result out: decoded byte, escape progress, segment
// ends, absorbed slashes, escape errors and discarded characters, with the running segment length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / ch_i) carries one character per
//   transfer; a NUL character ends the text. Output channel (out_valid_o /
//   out_ready_i) carries one result per character: kind_o, data_byte_o and
//   seg_length_o (decoded bytes so far, saturating at 65535).
//   Pipeline: a character is accepted into the input register, then moves
//   on to the result register, from which its result is presented and can
//   transfer.
//   Throughput: one character per cycle sustained while out_ready_i is high;
//   the only loop is the small parse state register (mode, pending high
//   nibble, byte count), updated when a character moves from the input
//   register into the result register.
//   Stall: when the receiver holds out_ready_i low, the result register
//   holds its value, the input register fills, and in_ready_o then drops;
//   nothing is lost or repeated. The two registers keep a full pipe moving.
//   Reset: rst_ni clears both valid flags and returns the parser to the
//   start of a segment with zero count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module uri_segment_percent_decoder import uspd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            ch_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            kind_o,
  output logic [7:0]            data_byte_o,
  output logic [ReportBits-1:0] seg_length_o
);

  // Input register
  logic          in_valid_q, in_valid_d;
  logic [7:0]    ch_q;
  // Result register
  logic          out_valid_q, out_valid_d;
  parse_result_t result_q;
  // Parser state
  parse_state_t  state_q, state_d;
  parse_result_t result_d;

  logic advance;
  logic in_xfer;

  // Move a character into the result register when the result slot is free
  // or is being taken this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_xfer || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  uspd_step u_step (
    .ch_i     (ch_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: ModeSeg, nibble: 4'h0, count: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      // Advance the parser only as a result is produced.
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ch_q <= ch_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = result_q.kind;
  assign data_byte_o  = result_q.data_byte;
  assign seg_length_o = result_q.seg_length;

  // Assertions
  a_data_only_for_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.kind != KindByte) |-> result_q.data_byte == 8'h00)
    else $error("data byte set on a non-byte result");

  a_zero_len_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (result_q.kind == KindAbsorbed || result_q.kind == KindDiscarded)
    |-> result_q.seg_length == '0)
    else $error("absorbed or discarded result carries a length");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after advance");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipe is full");

  a_esc_lo_follows_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(advance) && state_q.mode == ModeEscLo |-> result_q.kind == KindPending)
    else $error("awaiting low hex digit without a pending result");

endmodule
